// ===== rtl/core/scc_pkg.sv =====
// Shared constants and helpers for the seconds-count calendar converter.
package scc_pkg;

  localparam int unsigned BASE_YEAR = 2014;

  // Days from 1 January of year 1 to 1 January of the base year.
  localparam int unsigned DAYS_BEFORE_BASE = (BASE_YEAR - 1) * 365 + (BASE_YEAR - 1) / 4
                                           - (BASE_YEAR - 1) / 100 + (BASE_YEAR - 1) / 400;

  // Offset from the absolute day number to the Jalali day count.
  localparam int unsigned JALALI_OFFSET = 356033;
  localparam int unsigned JALALI_CYCLE  = 12053;
  localparam int unsigned JALALI_QUAD   = 1461;
  localparam int unsigned JALALI_BASE   = 1595;

  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;

  localparam logic [8:0] DAYS_BEFORE_MONTH [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // Gregorian leap test; cent is year / 100.
  function automatic logic is_leap(logic [11:0] year, logic [4:0] cent);
    logic [11:0] hund;
    hund = 12'(cent * 7'd100);
    return (year[1:0] == 2'b00) && ((year != hund) || (cent[1:0] == 2'b00));
  endfunction

  // Day of year at which month index m begins.
  function automatic logic [8:0] month_start(logic [3:0] m, logic leap);
    logic [8:0] base;
    base = DAYS_BEFORE_MONTH[m];
    return base + ((m >= 4'd2 && leap) ? 9'd1 : 9'd0);
  endfunction

endpackage

// ===== rtl/core/scc_clock_split.sv =====
// Time-of-day split into hour, minute and second over six register stages.
module scc_clock_split
  import scc_pkg::*;
(
  input  logic        clk_i,
  input  logic [16:0] tod_i,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o
);

  logic [16:0] tod_a_q;
  logic [4:0]  hr_a_q, hr_b_q, hr_c_q, hr_d_q, hr_e_q, hr_f_q;
  logic [11:0] mt_b_q, mt_c_q;
  logic [5:0]  mn_c_q, mn_d_q, mn_e_q, mn_f_q;
  logic [5:0]  sc_d_q, sc_e_q, sc_f_q;
  logic [32:0] hr_prod;
  logic [26:0] mn_prod;

  // Reciprocal products are exact for every time of day below 86400.
  assign hr_prod = 33'(tod_i * 16'd37283);
  assign mn_prod = 27'(mt_b_q * 15'd17477);

  always_ff @(posedge clk_i) begin
    tod_a_q <= tod_i;
    hr_a_q  <= hr_prod[31:27];
    mt_b_q  <= 12'(tod_a_q - 17'(hr_a_q * 12'(SECS_PER_HOUR)));
    hr_b_q  <= hr_a_q;
    mt_c_q  <= mt_b_q;
    mn_c_q  <= mn_prod[25:20];
    hr_c_q  <= hr_b_q;
    sc_d_q  <= 6'(mt_c_q - 12'(mn_c_q * 6'd60));
    mn_d_q  <= mn_c_q;
    hr_d_q  <= hr_c_q;
    sc_e_q  <= sc_d_q;
    mn_e_q  <= mn_d_q;
    hr_e_q  <= hr_d_q;
    sc_f_q  <= sc_e_q;
    mn_f_q  <= mn_e_q;
    hr_f_q  <= hr_e_q;
  end

  assign hour_o   = hr_f_q;
  assign minute_o = mn_f_q;
  assign second_o = sc_f_q;

endmodule

// ===== rtl/core/seconds_count_to_calendar.sv =====
// Top level: seconds count to Gregorian date, weekday, Jalali date and time of day.
//
// Usage: pulse start_i with seconds_count_i (seconds since 1 January of the
// base year, midnight). busy_o stays low, so an item is taken in every cycle
// that start_i is high. When an item has passed all pipeline stages, done_o is
// high for one cycle with all date and time fields of that item on the
// outputs; the fields are only meaningful in that cycle.
// Throughput is one item per cycle: an eight-stage pipeline, each stage about
// one constant multiplication plus an add and compare. Day, year and Jalali
// cycle splitting use reciprocal multiplies with a one- or two-step correction; the
// quad-year, year-in-quad and month searches are small parallel compares.
// Reset clears the stage valid bits only; no result appears until an item is
// taken. The receiver cannot stall the block, and none is needed: results
// leave in the order items came in, one per accepted item.
module seconds_count_to_calendar
  import scc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] seconds_count_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [11:0] greg_year_o,
  output logic [3:0]  greg_month_o,
  output logic [4:0]  greg_day_o,
  output logic [2:0]  weekday_o,
  output logic [10:0] jalali_year_o,
  output logic [3:0]  jalali_month_o,
  output logic [4:0]  jalali_day_o,
  output logic [4:0]  hour_of_day_o,
  output logic [5:0]  minute_of_hour_o,
  output logic [5:0]  second_of_minute_o
);

  logic [7:0] vld_q, vld_d;

  // stage 1
  logic [31:0] secs1_q;
  logic [15:0] dq1_q;
  logic [50:0] dq_prod;
  // stage 2
  logic [15:0] days2_q;
  logic [16:0] tod2_q;
  logic [31:0] rem2;
  // stage 3
  logic [19:0] abs3_q;
  // stage 4
  logic [19:0] abs4_q;
  logic [11:0] est4_q;
  logic [6:0]  jq4_q;
  logic [17:0] q7_4_q;
  logic [31:0] est_prod;
  logic [20:0] jd4;
  logic [39:0] jq_prod;
  logic [42:0] q7_prod;
  // stage 5
  logic [19:0] abs5_q;
  logic [11:0] est5_q;
  logic [4:0]  c0_5_q, c1_5_q, c2_5_q;
  logic [2:0]  wd5_q;
  logic [13:0] r1_5_q;
  logic [6:0]  jq5_q;
  logic [24:0] c0_prod, c1_prod, c2_prod;
  logic [20:0] jd5, jr5;
  // stage 6
  logic [19:0] abs6_q, s0_6_q, s1_6_q;
  logic [11:0] est6_q;
  logic        lp0_6_q, lp1_6_q, lp2_6_q;
  logic [2:0]  wd6_q;
  logic [6:0]  jq6_q;
  logic [3:0]  q2_6_q;
  logic [10:0] r2_6_q;
  logic [3:0]  q2_cnt;
  // stage 7
  logic [11:0] gy7_q;
  logic [8:0]  doy7_q;
  logic        lp7_q;
  logic [2:0]  wd7_q;
  logic [11:0] jy7_q;
  logic [8:0]  r3_7_q;
  logic [10:0] jt7;
  logic [1:0]  q3_cnt;
  logic [8:0]  r3_d;
  // stage 8
  logic [11:0] gy8_q;
  logic [3:0]  gm8_q, jm8_q;
  logic [4:0]  gd8_q, jd8_q;
  logic [2:0]  wd8_q;
  logic [10:0] jy8_q;
  logic [3:0]  gm_idx;
  logic [8:0]  gm_base;
  logic [2:0]  jk;
  logic [8:0]  jt8;

  assign busy_o = 1'b0;
  assign vld_d  = {vld_q[6:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Underestimate of day number, fixed by one step in stage 2.
  assign dq_prod = 51'(seconds_count_i[31:7] * 26'd50903316);
  assign rem2    = secs1_q - 32'(dq1_q * 17'(SECS_PER_DAY));

  assign est_prod = 32'(abs3_q * 12'd2871);
  assign jd4      = 21'(abs3_q) + 21'(JALALI_OFFSET);
  assign jq_prod  = 40'(jd4 * 19'd356340);
  assign q7_prod  = 43'((21'(abs3_q) + 21'd1) * 22'd2396746);

  assign c0_prod = 25'(est4_q * 13'd5243);
  assign c1_prod = 25'((est4_q + 12'd1) * 13'd5243);
  assign c2_prod = 25'((est4_q + 12'd2) * 13'd5243);
  assign jd5     = 21'(abs4_q) + 21'(JALALI_OFFSET);
  assign jr5     = jd5 - 21'(jq4_q * 14'(JALALI_CYCLE));

  always_comb begin
    q2_cnt = '0;
    for (int k = 1; k <= 8; k++) begin
      if (r1_5_q >= 14'(k * JALALI_QUAD)) q2_cnt = 4'(k);
    end
  end

  always_comb begin
    jt7    = r2_6_q - 11'd1;
    q3_cnt = '0;
    r3_d   = 9'(r2_6_q);
    if (r2_6_q > 11'd365) begin
      if (jt7 >= 11'd1095) q3_cnt = 2'd3;
      else if (jt7 >= 11'd730) q3_cnt = 2'd2;
      else if (jt7 >= 11'd365) q3_cnt = 2'd1;
      r3_d = 9'(jt7 - 11'(q3_cnt * 9'd365));
    end
  end

  always_comb begin
    gm_idx = '0;
    for (int k = 1; k < 12; k++) begin
      if (doy7_q >= month_start(4'(k), lp7_q)) gm_idx = 4'(k);
    end
    gm_base = month_start(gm_idx, lp7_q);
  end

  always_comb begin
    jk  = '0;
    jt8 = '0;
    if (r3_7_q < 9'd186) begin
      for (int k = 1; k <= 5; k++) begin
        if (r3_7_q >= 9'(k * 31)) jk = 3'(k);
      end
      jt8 = r3_7_q - 9'(jk * 5'd31);
    end else begin
      for (int k = 1; k <= 5; k++) begin
        if (r3_7_q - 9'd186 >= 9'(k * 30)) jk = 3'(k);
      end
      jt8 = r3_7_q - 9'd186 - 9'(jk * 5'd30);
    end
  end

  always_ff @(posedge clk_i) begin
    // stage 1
    secs1_q <= seconds_count_i;
    dq1_q   <= dq_prod[50:35];
    // stage 2
    if (rem2 >= 32'(SECS_PER_DAY)) begin
      days2_q <= dq1_q + 16'd1;
      tod2_q  <= 17'(rem2 - 32'(SECS_PER_DAY));
    end else begin
      days2_q <= dq1_q;
      tod2_q  <= 17'(rem2);
    end
    // stage 3: absolute day number from 1 January of year 1
    abs3_q <= 20'(days2_q) + 20'(DAYS_BEFORE_BASE);
    // stage 4
    abs4_q <= abs3_q;
    est4_q <= est_prod[31:20];
    jq4_q  <= jq_prod[38:32];
    q7_4_q <= q7_prod[41:24];
    // stage 5
    abs5_q <= abs4_q;
    est5_q <= est4_q;
    c0_5_q <= c0_prod[23:19];
    c1_5_q <= c1_prod[23:19];
    c2_5_q <= c2_prod[23:19];
    wd5_q  <= 3'(21'(abs4_q) + 21'd1 - 21'(q7_4_q * 3'd7));
    if (jr5 >= 21'(JALALI_CYCLE)) begin
      r1_5_q <= 14'(jr5 - 21'(JALALI_CYCLE));
      jq5_q  <= jq4_q + 7'd1;
    end else begin
      r1_5_q <= 14'(jr5);
      jq5_q  <= jq4_q;
    end
    // stage 6: start of year candidates and leap flags
    abs6_q  <= abs5_q;
    est6_q  <= est5_q;
    s0_6_q  <= 20'(est5_q * 9'd365) + 20'(est5_q >> 2) - 20'(c0_5_q) + 20'(c0_5_q >> 2);
    s1_6_q  <= 20'((est5_q + 12'd1) * 9'd365) + 20'((est5_q + 12'd1) >> 2)
             - 20'(c1_5_q) + 20'(c1_5_q >> 2);
    lp0_6_q <= is_leap(est5_q, c0_5_q);
    lp1_6_q <= is_leap(est5_q + 12'd1, c1_5_q);
    lp2_6_q <= is_leap(est5_q + 12'd2, c2_5_q);
    wd6_q   <= wd5_q;
    jq6_q   <= jq5_q;
    q2_6_q  <= q2_cnt;
    r2_6_q  <= 11'(r1_5_q - 14'(q2_cnt * 11'(JALALI_QUAD)));
    // stage 7: pick the year that holds the day
    if (abs6_q >= s1_6_q) begin
      gy7_q  <= est6_q + 12'd2;
      doy7_q <= 9'(abs6_q - s1_6_q);
      lp7_q  <= lp2_6_q;
    end else if (abs6_q < s0_6_q) begin
      gy7_q  <= est6_q;
      doy7_q <= 9'(21'(abs6_q) + 21'd365 + 21'(lp0_6_q) - 21'(s0_6_q));
      lp7_q  <= lp0_6_q;
    end else begin
      gy7_q  <= est6_q + 12'd1;
      doy7_q <= 9'(abs6_q - s0_6_q);
      lp7_q  <= lp1_6_q;
    end
    wd7_q  <= wd6_q;
    jy7_q  <= 12'(jq6_q * 6'd33) + 12'(q2_6_q * 3'd4) + 12'(q3_cnt) - 12'(JALALI_BASE);
    r3_7_q <= r3_d;
    // stage 8: months and days
    gy8_q <= gy7_q;
    gm8_q <= gm_idx + 4'd1;
    gd8_q <= 5'(doy7_q - gm_base + 9'd1);
    wd8_q <= wd7_q;
    jy8_q <= jy7_q[10:0];
    jm8_q <= (r3_7_q < 9'd186) ? 4'(jk) + 4'd1 : 4'(jk) + 4'd7;
    jd8_q <= 5'(jt8 + 9'd1);
  end

  scc_clock_split u_clock_split (
    .clk_i    (clk_i),
    .tod_i    (tod2_q),
    .hour_o   (hour_of_day_o),
    .minute_o (minute_of_hour_o),
    .second_o (second_of_minute_o)
  );

  assign done_o         = vld_q[7];
  assign greg_year_o    = gy8_q;
  assign greg_month_o   = gm8_q;
  assign greg_day_o     = gd8_q;
  assign weekday_o      = wd8_q;
  assign jalali_year_o  = jy8_q;
  assign jalali_month_o = jm8_q;
  assign jalali_day_o   = jd8_q;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(vld_q[0], 7))
    else $error("result without a matching item");
  a_greg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (greg_month_o >= 4'd1) && (greg_month_o <= 4'd12) && (greg_day_o >= 5'd1))
    else $error("Gregorian month or day out of range");
  a_weekday: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (weekday_o <= 3'd6) && (jalali_month_o >= 4'd1) && (jalali_month_o <= 4'd12))
    else $error("weekday or Jalali month out of range");
`endif

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the seconds-count to calendar converter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned LATENCY     = 8;

  typedef struct packed {
    logic [11:0] gy;
    logic [3:0]  gm;
    logic [4:0]  gd;
    logic [2:0]  wd;
    logic [10:0] jy;
    logic [3:0]  jm;
    logic [4:0]  jd;
    logic [4:0]  hh;
    logic [5:0]  mm;
    logic [5:0]  ss;
  } cal_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [31:0] seconds_count_i = '0;
  logic        busy_o, done_o;
  logic [11:0] greg_year_o;
  logic [3:0]  greg_month_o, jalali_month_o;
  logic [4:0]  greg_day_o, jalali_day_o, hour_of_day_o;
  logic [2:0]  weekday_o;
  logic [10:0] jalali_year_o;
  logic [5:0]  minute_of_hour_o, second_of_minute_o;

  logic [31:0] pending_counts[$];
  cal_t        expected_dates[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_left = 0, burst_left = 0;
  int unsigned n_sent = 0, n_checked = 0;
  logic        rst_done = 1'b0;

  always #4 clk_i = ~clk_i;

  seconds_count_to_calendar dut (.*);

  function automatic bit leap_year(int y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic cal_t calendar_of(logic [31:0] secs);
    int wk_off[12] = '{0, 3, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};
    int mlen[12]   = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    int days_ahead[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    longint days, tod, yr, mi, ln, y2, jd_cnt, jyr, t, yl;
    cal_t r;
    days = secs / 86400;
    tod  = secs % 86400;
    yr   = scc_pkg::BASE_YEAR;
    mi   = 0;
    while (days >= 365) begin
      if (leap_year(yr)) begin
        if (days >= 366) days -= 366;
        else break;
      end else begin
        days -= 365;
      end
      yr++;
    end
    while (days >= 28 && mi < 11) begin
      ln = mlen[mi];
      if (mi == 1 && leap_year(yr)) ln = 29;
      if (days < ln) break;
      days -= ln;
      mi++;
    end
    r.gy = yr[11:0];
    r.gm = 4'(mi + 1);
    r.gd = 5'(days + 1);
    // century-corrected table rule
    yl = yr - 1900;
    t = yl + yl / 4 - yr / 100 + yr / 400 + 15 + days + 1 + wk_off[mi];
    if (leap_year(yr) && mi < 2) t -= 1;
    t %= 7;
    if (t < 0) t += 7;
    r.wd = 3'(t);
    y2 = (mi >= 2) ? yr + 1 : yr;
    jd_cnt = 355666 + 365 * yr + (y2 + 3) / 4 - (y2 + 99) / 100 + (y2 + 399) / 400
             + days + 1 + days_ahead[mi];
    jyr = -1595 + 33 * (jd_cnt / 12053);
    jd_cnt %= 12053;
    jyr += 4 * (jd_cnt / 1461);
    jd_cnt %= 1461;
    if (jd_cnt > 365) begin
      jyr += (jd_cnt - 1) / 365;
      jd_cnt = (jd_cnt - 1) % 365;
    end
    r.jy = 11'(jyr);
    if (jd_cnt < 186) begin
      r.jm = 4'(1 + jd_cnt / 31);
      r.jd = 5'(1 + jd_cnt % 31);
    end else begin
      r.jm = 4'(7 + (jd_cnt - 186) / 30);
      r.jd = 5'(1 + (jd_cnt - 186) % 30);
    end
    r.hh = 5'(tod / 3600);
    r.mm = 6'((tod % 3600) / 60);
    r.ss = 6'(tod % 60);
    return r;
  endfunction

  // Driver: bursts of items separated by random gaps.
  always @(posedge clk_i) begin
    if (rst_done) begin
      if (start_i && !busy_o) begin
        expected_dates.push_back(calendar_of(seconds_count_i));
        n_sent++;
      end
      if (!(start_i && busy_o)) begin
        if (gap_left > 0 || pending_counts.size() == 0) begin
          if (gap_left > 0) gap_left--;
          start_i <= 1'b0;
        end else begin
          start_i <= 1'b1;
          seconds_count_i <= pending_counts.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
          end
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk_i) begin
    cal_t got, exp_d;
    if (done_o) begin
      got = '{greg_year_o, greg_month_o, greg_day_o, weekday_o, jalali_year_o,
              jalali_month_o, jalali_day_o, hour_of_day_o, minute_of_hour_o,
              second_of_minute_o};
      if (expected_dates.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        exp_d = expected_dates.pop_front();
        n_checked++;
        if (got !== exp_d) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_d, got);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with nothing accepted or returned.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[seconds_count_to_calendar] ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] date_secs(int y, int doy);
    longint d;
    d = doy;
    for (int k = scc_pkg::BASE_YEAR; k < y; k++) d += leap_year(k) ? 366 : 365;
    return 32'(d * 86400 + $urandom_range(0, 86399));
  endfunction

  initial begin
    logic [31:0] v;
    pending_counts.push_back(32'h0000_0000);
    pending_counts.push_back(32'hFFFF_FFFF);
    pending_counts.push_back(32'd86399);
    pending_counts.push_back(32'd86400);
    pending_counts.push_back(32'hAAAA_AAAA);
    pending_counts.push_back(32'h5555_5555);
    // leap-day and year-end edges, including 2100 (not leap) and 2400-less range
    pending_counts.push_back(date_secs(2016, 365));
    pending_counts.push_back(date_secs(2016, 59));
    pending_counts.push_back(date_secs(2016, 58));
    pending_counts.push_back(date_secs(2100, 58));
    pending_counts.push_back(date_secs(2100, 59));
    pending_counts.push_back(date_secs(2100, 364));
    pending_counts.push_back(date_secs(2101, 0));
    pending_counts.push_back(date_secs(2148, 365));
    pending_counts.push_back(date_secs(2020, 79));
    pending_counts.push_back(date_secs(2024, 80));
    pending_counts.push_back(date_secs(2099, 364));
    for (int i = 0; i < 800; i++) begin
      case ($urandom_range(0, 3))
        0: v = $urandom();
        1: v = date_secs($urandom_range(2014, 2149), $urandom_range(0, 364));
        2: v = date_secs(4 * $urandom_range(504, 537), 365);
        default: v = date_secs($urandom_range(2014, 2149), $urandom_range(55, 85));
      endcase
      pending_counts.push_back(v);
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    rst_done <= 1'b1;
    wait (pending_counts.size() == 0 && !start_i);
    wait (expected_dates.size() == 0);
    repeat (LATENCY + 4) @(posedge clk_i);
    $display("Sent %0d seconds counts, checked %0d calendar results", n_sent, n_checked);
    $display("Covered leap-year ends, century year 2100 and the full 32-bit range");
    if (errors == 0 && expected_dates.size() == 0)
      $display("[seconds_count_to_calendar] OK");
    else
      $display("[seconds_count_to_calendar] ERROR");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/scc_pkg.sv
rtl/core/scc_clock_split.sv
rtl/core/seconds_count_to_calendar.sv
verif/tb_top.sv
